### sv/tpid_pkg.sv
// Package for the two-axis PID core: payload types, register codes and fixed-point helpers.
`default_nettype none
package tpid_pkg;

  localparam int unsigned DataW = 32;          // Q16.16 word
  localparam int unsigned FracW = 16;          // fraction bits
  localparam int unsigned CfgIdxW = 3;         // eight coefficient registers
  localparam int unsigned ProdW = 66;          // coefficient times 33-bit operand, with headroom
  localparam int unsigned AccW = ProdW - FracW; // width of a rescaled product and its sums
  localparam int unsigned NumAxes = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN_RADIAL   = 3'd0,
    REG_INTEG_COEF_RADIAL  = 3'd1,
    REG_DERIV_COEF_RADIAL  = 3'd2,
    REG_DERIV_POLE_RADIAL  = 3'd3,
    REG_PROP_GAIN_ANGULAR  = 3'd4,
    REG_INTEG_COEF_ANGULAR = 3'd5,
    REG_DERIV_COEF_ANGULAR = 3'd6,
    REG_DERIV_POLE_ANGULAR = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    AXIS_RADIAL  = 1'b0,
    AXIS_ANGULAR = 1'b1
  } axis_e;

  typedef struct packed {
    logic                    axis;
    logic signed [DataW-1:0] error_now;
    logic signed [DataW-1:0] error_prev;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] command;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] kp;
    logic signed [DataW-1:0] ic;
    logic signed [DataW-1:0] dc;
    logic signed [DataW-1:0] pole;
  } pid_coef_t;

  typedef struct packed {
    logic                    clip;
    logic signed [DataW-1:0] val;
  } sat_t;

  // (a*b) / 2^16, rounded to nearest with halves away from zero
  function automatic logic signed [AccW-1:0] qmul(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW:0]   b);
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] rnd;
    prod = ProdW'(a) * ProdW'(b);
    // bias negative products by one less so exact halves round away from zero
    rnd = prod + (prod[ProdW-1] ? ProdW'(signed'(17'h07FFF)) : ProdW'(signed'(17'h08000)));
    return rnd[ProdW-1:FracW];
  endfunction

  // clamp to the signed 32-bit range and flag a clip
  function automatic sat_t sat32(input logic signed [AccW-1:0] v);
    sat_t r;
    logic signed [AccW-1:0] max_v;
    logic signed [AccW-1:0] min_v;
    max_v = AccW'(signed'({1'b0, {(DataW-1){1'b1}}}));
    min_v = AccW'(signed'({1'b1, {(DataW-1){1'b0}}}));
    r.clip = 1'b0;
    r.val  = v[DataW-1:0];
    if (v > max_v) begin
      r.clip = 1'b1;
      r.val  = max_v[DataW-1:0];
    end else if (v < min_v) begin
      r.clip = 1'b1;
      r.val  = min_v[DataW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/tustin_pid_two_axis_core.sv
// Two-axis PID core: trapezoidal integral, Tustin-filtered derivative, saturated Q16.16 output.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | in        | in_valid_i / in_ready_o   | in_item_i  (axis, error_now, error_prev)
//  out     | out       | out_valid_o / out_ready_i | out_item_o (command, saturated)
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled; a result passes from the input
// register through the multiply/add/clamp pass into the result register.
// The per-axis integral and derivative are updated as the item moves into the
// result register, so an item on the same axis may follow in the next cycle.
// Reset clears coefficients and stored terms to zero. A stalled output holds the
// pipe; the input register still fills, so one item waits behind the result.
`default_nettype none
module tustin_pid_two_axis_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire tpid_pkg::in_item_t       in_item_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output tpid_pkg::out_item_t           out_item_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [tpid_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [tpid_pkg::DataW-1:0]     cfg_data_i
);

  localparam int unsigned DataW = tpid_pkg::DataW;
  localparam int unsigned AccW  = tpid_pkg::AccW;

  tpid_pkg::pid_coef_t rad_q, ang_q;
  tpid_pkg::in_item_t  s1_item_q;
  logic                s1_valid_q, s1_valid_d;
  tpid_pkg::out_item_t out_item_q, out_item_d;
  logic                out_valid_q, out_valid_d;
  logic signed [DataW-1:0] integ_q [tpid_pkg::NumAxes];
  logic signed [DataW-1:0] deriv_q [tpid_pkg::NumAxes];

  logic in_xfer, adv;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= '0;
      ang_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (tpid_pkg::cfg_reg_e'(cfg_index_i))
        tpid_pkg::REG_PROP_GAIN_RADIAL:   rad_q.kp   <= cfg_data_i;
        tpid_pkg::REG_INTEG_COEF_RADIAL:  rad_q.ic   <= cfg_data_i;
        tpid_pkg::REG_DERIV_COEF_RADIAL:  rad_q.dc   <= cfg_data_i;
        tpid_pkg::REG_DERIV_POLE_RADIAL:  rad_q.pole <= cfg_data_i;
        tpid_pkg::REG_PROP_GAIN_ANGULAR:  ang_q.kp   <= cfg_data_i;
        tpid_pkg::REG_INTEG_COEF_ANGULAR: ang_q.ic   <= cfg_data_i;
        tpid_pkg::REG_DERIV_COEF_ANGULAR: ang_q.dc   <= cfg_data_i;
        tpid_pkg::REG_DERIV_POLE_ANGULAR: ang_q.pole <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
  end

  // ---------------- datapath ----------------
  tpid_pkg::pid_coef_t     coef;
  logic                    ax;
  logic signed [DataW:0]   e_sum, e_diff;
  logic signed [AccW-1:0]  p_raw, i_raw, d_raw, total;
  tpid_pkg::sat_t          p_sat, i_sat, d_sat, s_sat;

  always_comb begin
    ax     = s1_item_q.axis;
    coef   = (tpid_pkg::axis_e'(ax) == tpid_pkg::AXIS_ANGULAR) ? ang_q : rad_q;
    e_sum  = (DataW+1)'(s1_item_q.error_now) + (DataW+1)'(s1_item_q.error_prev);
    e_diff = (DataW+1)'(s1_item_q.error_now) - (DataW+1)'(s1_item_q.error_prev);
    p_raw  = tpid_pkg::qmul(coef.kp, (DataW+1)'(s1_item_q.error_now));
    i_raw  = tpid_pkg::qmul(coef.ic, e_sum) + AccW'(integ_q[ax]);
    d_raw  = tpid_pkg::qmul(coef.dc, e_diff)
           - tpid_pkg::qmul(coef.pole, (DataW+1)'(deriv_q[ax]));
    p_sat  = tpid_pkg::sat32(p_raw);
    i_sat  = tpid_pkg::sat32(i_raw);
    d_sat  = tpid_pkg::sat32(d_raw);
    total  = AccW'(p_sat.val) + AccW'(i_sat.val) + AccW'(d_sat.val);
    s_sat  = tpid_pkg::sat32(total);
    out_item_d.command   = s_sat.val;
    out_item_d.saturated = p_sat.clip | i_sat.clip | d_sat.clip | s_sat.clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      deriv_q[0] <= '0;
      deriv_q[1] <= '0;
    end else if (adv) begin
      // current terms become this axis's previous terms
      integ_q[ax] <= i_sat.val;
      deriv_q[ax] <= d_sat.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------- assertions ----------------
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advance did not produce a result");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(integ_q[0]) && $stable(integ_q[1])
             && $stable(deriv_q[0]) && $stable(deriv_q[1]))
    else $error("stored terms changed without an advance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipe");

endmodule
`default_nettype wire

### tb/sv/tustin_pid_two_axis_core_test.sv
// Self-checking testbench for the two-axis PID core: directed corner table, then random phases.
`timescale 1ns / 1ps
module tustin_pid_two_axis_core_test;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [31:0] Q_NEG_ONE = 32'shFFFF_0000;
  localparam logic signed [31:0] Q_NEG_HALF = 32'shFFFF_8000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]      gset;
    tpid_pkg::axis_e axis;
    logic [31:0]     e_now;
    logic [31:0]     e_prev;
    logic            typed;
    logic [31:0]     cmd;
    logic            sat;
  } probe_row_t;

  // gain sets per axis: radial, angular; fields kp, ic, dc, pole
  tpid_pkg::pid_coef_t gain_sets [4][2] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}},
    '{'{Q_MAX, 32'sd0, 32'sd0, 32'sd0}, '{Q_MIN, 32'sd0, 32'sd0, 32'sd0}},
    '{'{Q_HALF, Q_HALF, Q_ONE, Q_NEG_HALF}, '{Q_ONE, Q_MAX, Q_MIN, Q_MAX}},
    '{'{32'sd0, 32'sd0, Q_MAX, Q_MIN}, '{Q_NEG_ONE, Q_MIN, 32'sd1, 32'sd1}}
  };

  probe_row_t probe_rows [23] = '{
    // reset gains: every command is zero
    '{2'd0, tpid_pkg::AXIS_RADIAL, Q_MAX, Q_MIN, 1'b1, 32'sd0, 1'b0},
    '{2'd0, tpid_pkg::AXIS_ANGULAR, Q_MIN, Q_MAX, 1'b1, 32'sd0, 1'b0},
    '{2'd0, tpid_pkg::AXIS_RADIAL, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0},
    '{2'd0, tpid_pkg::AXIS_ANGULAR, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, 32'sd0, 1'b0},
    // extreme proportional gains: large errors clip the command, zero and small ones do not
    '{2'd1, tpid_pkg::AXIS_RADIAL, Q_MAX, 32'sd0, 1'b1, Q_MAX, 1'b1},
    '{2'd1, tpid_pkg::AXIS_RADIAL, Q_MIN, 32'sd0, 1'b1, Q_MIN, 1'b1},
    '{2'd1, tpid_pkg::AXIS_ANGULAR, Q_MAX, 32'sd0, 1'b1, Q_MIN, 1'b1},
    '{2'd1, tpid_pkg::AXIS_ANGULAR, Q_MIN, 32'sd0, 1'b1, Q_MAX, 1'b1},
    '{2'd1, tpid_pkg::AXIS_ANGULAR, 32'sd0, Q_MAX, 1'b1, 32'sd0, 1'b0},
    '{2'd1, tpid_pkg::AXIS_RADIAL, 32'sd1, 32'sd0, 1'b0, 32'sd0, 1'b0},
    // rounding of halves, 33-bit sums and differences, integral windup
    '{2'd2, tpid_pkg::AXIS_RADIAL, 32'sd1, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{2'd2, tpid_pkg::AXIS_RADIAL, 32'shFFFF_FFFF, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{2'd2, tpid_pkg::AXIS_RADIAL, 32'sd1, 32'sd1, 1'b0, 32'sd0, 1'b0},
    '{2'd2, tpid_pkg::AXIS_RADIAL, Q_MAX, Q_MAX, 1'b0, 32'sd0, 1'b0},
    '{2'd2, tpid_pkg::AXIS_RADIAL, Q_MIN, Q_MIN, 1'b0, 32'sd0, 1'b0},
    '{2'd2, tpid_pkg::AXIS_ANGULAR, Q_MAX, Q_MIN, 1'b0, 32'sd0, 1'b0},
    '{2'd2, tpid_pkg::AXIS_ANGULAR, Q_MIN, Q_MAX, 1'b0, 32'sd0, 1'b0},
    '{2'd2, tpid_pkg::AXIS_ANGULAR, Q_MAX, Q_MAX, 1'b0, 32'sd0, 1'b0},
    // extreme radial derivative coefficient and feedback pole, extreme angular integral coefficient
    '{2'd3, tpid_pkg::AXIS_RADIAL, Q_MAX, Q_MIN, 1'b0, 32'sd0, 1'b0},
    '{2'd3, tpid_pkg::AXIS_RADIAL, Q_MIN, Q_MAX, 1'b0, 32'sd0, 1'b0},
    '{2'd3, tpid_pkg::AXIS_RADIAL, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{2'd3, tpid_pkg::AXIS_ANGULAR, Q_MIN, Q_MIN, 1'b0, 32'sd0, 1'b0},
    '{2'd3, tpid_pkg::AXIS_ANGULAR, 32'sd1, 32'shFFFF_FFFF, 1'b0, 32'sd0, 1'b0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  tpid_pkg::in_item_t  in_item = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  tpid_pkg::cfg_reg_e  cfg_index = tpid_pkg::REG_PROP_GAIN_RADIAL;
  logic [31:0]         cfg_data = '0;

  logic                in_ready_o;
  logic                out_valid_o;
  tpid_pkg::out_item_t out_item_o;
  logic                cfg_ready_o;

  tpid_pkg::pid_coef_t axis_gain [2];
  longint    integ_acc [2];
  longint    deriv_acc [2];
  tpid_pkg::out_item_t command_q [$];
  logic signed [31:0] last_err [2];
  int        err_count = 0;
  int unsigned quiet_cycles = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  bit        quiet_tail = 1'b0;
  bit        hold_req = 1'b0;

  tustin_pid_two_axis_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // (a*b) / 2^16, rounded to nearest, halves away from zero
  function automatic longint q16_mul(longint a, longint b);
    logic signed [95:0] wa;
    logic signed [95:0] wb;
    logic signed [95:0] prod;
    logic [95:0] mag;
    longint r;
    wa = a;
    wb = b;
    prod = wa * wb;
    mag = prod[95] ? -prod : prod;
    r = longint'((mag + 96'd32768) >> 16);
    return prod[95] ? -r : r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // advance the per-axis integral and filtered derivative, return the command
  function automatic tpid_pkg::out_item_t pid_step(tpid_pkg::in_item_t it);
    tpid_pkg::pid_coef_t g;
    longint en, ep, raw, p, i, d, s;
    bit clip;
    tpid_pkg::out_item_t res;
    g = axis_gain[it.axis];
    en = longint'(it.error_now);
    ep = longint'(it.error_prev);
    clip = 1'b0;
    raw = q16_mul(g.kp, en);
    p = clamp32(raw);
    clip |= (p != raw);
    raw = q16_mul(g.ic, en + ep) + integ_acc[it.axis];
    i = clamp32(raw);
    clip |= (i != raw);
    raw = q16_mul(g.dc, en - ep) - q16_mul(g.pole, deriv_acc[it.axis]);
    d = clamp32(raw);
    clip |= (d != raw);
    raw = p + i + d;
    s = clamp32(raw);
    clip |= (s != raw);
    integ_acc[it.axis] = i;
    deriv_acc[it.axis] = d;
    res.command = s[31:0];
    res.saturated = clip;
    return res;
  endfunction

  task automatic write_reg(input tpid_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tpid_pkg::REG_PROP_GAIN_RADIAL:   axis_gain[tpid_pkg::AXIS_RADIAL].kp = val;
      tpid_pkg::REG_INTEG_COEF_RADIAL:  axis_gain[tpid_pkg::AXIS_RADIAL].ic = val;
      tpid_pkg::REG_DERIV_COEF_RADIAL:  axis_gain[tpid_pkg::AXIS_RADIAL].dc = val;
      tpid_pkg::REG_DERIV_POLE_RADIAL:  axis_gain[tpid_pkg::AXIS_RADIAL].pole = val;
      tpid_pkg::REG_PROP_GAIN_ANGULAR:  axis_gain[tpid_pkg::AXIS_ANGULAR].kp = val;
      tpid_pkg::REG_INTEG_COEF_ANGULAR: axis_gain[tpid_pkg::AXIS_ANGULAR].ic = val;
      tpid_pkg::REG_DERIV_COEF_ANGULAR: axis_gain[tpid_pkg::AXIS_ANGULAR].dc = val;
      tpid_pkg::REG_DERIV_POLE_ANGULAR: axis_gain[tpid_pkg::AXIS_ANGULAR].pole = val;
      default: ;
    endcase
  endtask

  task automatic write_gains(input tpid_pkg::pid_coef_t rad, input tpid_pkg::pid_coef_t ang);
    write_reg(tpid_pkg::REG_PROP_GAIN_RADIAL, rad.kp);
    write_reg(tpid_pkg::REG_INTEG_COEF_RADIAL, rad.ic);
    write_reg(tpid_pkg::REG_DERIV_COEF_RADIAL, rad.dc);
    write_reg(tpid_pkg::REG_DERIV_POLE_RADIAL, rad.pole);
    write_reg(tpid_pkg::REG_PROP_GAIN_ANGULAR, ang.kp);
    write_reg(tpid_pkg::REG_INTEG_COEF_ANGULAR, ang.ic);
    write_reg(tpid_pkg::REG_DERIV_COEF_ANGULAR, ang.dc);
    write_reg(tpid_pkg::REG_DERIV_POLE_ANGULAR, ang.pole);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(input tpid_pkg::in_item_t it, input bit typed,
                           input tpid_pkg::out_item_t fixed_res);
    tpid_pkg::out_item_t res;
    if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready_o);
    res = pid_step(it);
    if (typed) res = fixed_res;
    command_q.push_back(res);
  endtask

  // hold the input until every outstanding command has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (command_q.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_coef(bit is_pole);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return Q_MAX;
      2: return Q_MIN;
      default: begin
        if (is_pole) return int'($urandom_range(0, 131072)) - 65536;
        return int'($urandom_range(0, 524288)) - 262144;
      end
    endcase
  endfunction

  function automatic tpid_pkg::pid_coef_t pick_gains();
    tpid_pkg::pid_coef_t g;
    g.kp = pick_coef(1'b0);
    g.ic = pick_coef(1'b0);
    g.dc = pick_coef(1'b0);
    g.pole = pick_coef(1'b1);
    return g;
  endfunction

  function automatic logic signed [31:0] pick_err();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return 32'sd0;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  // mostly a tracking sequence per axis: the previous error is the last current error
  function automatic tpid_pkg::in_item_t random_item();
    tpid_pkg::in_item_t it;
    it.axis = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) begin
      it.error_prev = last_err[it.axis];
      it.error_now = last_err[it.axis] + (int'($urandom_range(0, 131072)) - 65536);
    end else begin
      it.error_prev = pick_err();
      it.error_now = pick_err();
    end
    last_err[it.axis] = it.error_now;
    return it;
  endfunction

  task automatic check_command(input tpid_pkg::out_item_t got);
    tpid_pkg::out_item_t want;
    if (command_q.size() == 0) begin
      $error("command %0d arrived with no result pending", got.command);
      err_count++;
    end else begin
      want = command_q.pop_front();
      if (got.command !== want.command) begin
        $error("command: expected %0d, actual %0d", want.command, got.command);
        err_count++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        err_count++;
      end
    end
  endtask

  // result side: check each transfer, then pick the next ready level
  initial begin
    int stall_left;
    bit next_ready;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && out_ready) check_command(out_item_o);
        if (stall_left > 0) begin
          stall_left--;
          next_ready = 1'b0;
        end else if (hold_req) begin
          hold_req = 1'b0;
          stall_left = HOLD_CYCLES - 1;
          next_ready = 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 99) < rx_stall_pct) begin
          stall_left = $urandom_range(0, 10);
          next_ready = 1'b0;
        end else begin
          next_ready = 1'b1;
        end
        out_ready <= next_ready;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[tustin_pid_two_axis_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0] cur_set;
    tpid_pkg::in_item_t it;
    tpid_pkg::out_item_t fixed_res;
    for (int a = 0; a < 2; a++) begin
      axis_gain[a] = '0;
      integ_acc[a] = 0;
      deriv_acc[a] = 0;
      last_err[a] = '0;
    end
    cur_set = 2'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (probe_rows[r]) begin
      if (probe_rows[r].gset != cur_set) begin
        drain_results();
        cur_set = probe_rows[r].gset;
        write_gains(gain_sets[cur_set][tpid_pkg::AXIS_RADIAL],
                    gain_sets[cur_set][tpid_pkg::AXIS_ANGULAR]);
      end
      it.axis = probe_rows[r].axis;
      it.error_now = probe_rows[r].e_now;
      it.error_prev = probe_rows[r].e_prev;
      fixed_res.command = probe_rows[r].cmd;
      fixed_res.saturated = probe_rows[r].sat;
      push_item(it, probe_rows[r].typed, fixed_res);
    end
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiet_tail = (ph == NUM_PHASES - 1);
      tx_idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 8 : 30);
      rx_stall_pct = ((ph + 1) % 3 == 0) ? 0 : (((ph + 1) % 3 == 1) ? 8 : 30);
      write_gains(pick_gains(), pick_gains());
      // long output stall while items keep coming, so the input backs up
      if (ph == 1) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) push_item(random_item(), 1'b0, '0);
      drain_results();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[tustin_pid_two_axis_core] OK");
    end else begin
      $display("[tustin_pid_two_axis_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/tpid_pkg.sv
sv/tustin_pid_two_axis_core.sv
tb/sv/tustin_pid_two_axis_core_test.sv
